// ----- design/keyed_record_table_compacting_defines.svh -----
// Assertion macros shared by the record table RTL.
`ifndef KEYED_RECORD_TABLE_COMPACTING_DEFINES_SVH
`define KEYED_RECORD_TABLE_COMPACTING_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define KRTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Antecedent implies consequent in the next cycle.
`define KRTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- design/krtc_pkg.sv -----
// Shared constants, types and helpers of the record table.
`default_nettype none

package krtc_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int GRADE_W   = 5;
    localparam int GRD_W     = 4 * GRADE_W;
    localparam int REC_W     = GRD_W + KEY_W;
    localparam int SUM_W     = 7;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    localparam logic [GRADE_W-1:0] GRADE_MAX     = GRADE_W'(20);
    localparam logic [SUM_W-1:0]   THRESH_RESET  = SUM_W'(42);

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic             match;
        logic [SUM_W-1:0] sum;
        logic             passed;
    } t_unit_res;

    function automatic logic [GRADE_W-1:0] sat_grade(input logic [GRADE_W-1:0] g);
        sat_grade = (g > GRADE_MAX) ? GRADE_MAX : g;
    endfunction

endpackage

`default_nettype wire

// ----- design/krtc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module krtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/krtc_unit.sv -----
// Shared compare unit: key match, grade sum and pass test.
`default_nettype none

module krtc_unit (
    input  wire logic [krtc_pkg::KEY_W-1:0] i_key_a,
    input  wire logic [krtc_pkg::KEY_W-1:0] i_key_b,
    input  wire logic [krtc_pkg::GRD_W-1:0] i_grades,
    input  wire logic [krtc_pkg::SUM_W-1:0] i_threshold,
    output      krtc_pkg::t_unit_res        o_res
);
    import krtc_pkg::*;

    logic [SUM_W-1:0] sum;

    assign sum = SUM_W'(i_grades[GRADE_W-1:0])
               + SUM_W'(i_grades[2*GRADE_W-1:GRADE_W])
               + SUM_W'(i_grades[3*GRADE_W-1:2*GRADE_W])
               + SUM_W'(i_grades[4*GRADE_W-1:3*GRADE_W]);

    assign o_res.match  = (i_key_a == i_key_b);
    assign o_res.sum    = sum;
    assign o_res.passed = (sum >= i_threshold);

endmodule

`default_nettype wire

// ----- design/keyed_record_table_compacting.sv -----
// Record table top level: add, find, compacting delete and read of keyed records.
//
// Input channel: i_valid / o_stall with one request per accepted item (i_op, key,
// four grades, slot). The block takes one request at a time and holds o_stall high
// from acceptance until the result has been loaded into the output register.
// Output channel: o_valid / i_stall, one result per request from a registered
// output stage; a stalled result holds until taken, and a new request can be
// accepted meanwhile.
// Configuration: i_cfg_valid / o_cfg_ready writes the pass threshold; always ready.
// Add, a full add, an out-of-range read and a search of an empty table go straight
// to the done state; a read passes through the read and capture states; find
// and delete search the table, and a delete that hits shifts the later entries
// down. Search and shift share the single RAM read port one entry per cycle.
// The next request can be accepted in the cycle after the result loads.
// A stalled output register holds a finished result in the done state.
// Reset: synchronous, active low; clears the entry count, sets the threshold to
// 42 and empties the output register. Stored records need no clearing since
// only records below the entry count are ever used.
`default_nettype none

`include "keyed_record_table_compacting_defines.svh"

module keyed_record_table_compacting (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [krtc_pkg::SUM_W-1:0]       i_cfg_data,
    input  wire logic                             i_valid,
    output      logic                             o_stall,
    input  wire logic [krtc_pkg::OP_W-1:0]        i_op,
    input  wire logic [krtc_pkg::KEY_W-1:0]       i_key_code,
    input  wire logic [krtc_pkg::GRADE_W-1:0]     i_grade_a,
    input  wire logic [krtc_pkg::GRADE_W-1:0]     i_grade_b,
    input  wire logic [krtc_pkg::GRADE_W-1:0]     i_grade_c,
    input  wire logic [krtc_pkg::GRADE_W-1:0]     i_grade_d,
    input  wire logic [krtc_pkg::POS_W-1:0]       i_slot_position,
    output      logic                             o_valid,
    input  wire logic                             i_stall,
    output      logic [krtc_pkg::STATUS_W-1:0]    o_status,
    output      logic [krtc_pkg::POS_W-1:0]       o_hit_position,
    output      logic [krtc_pkg::KEY_W-1:0]       o_found_code,
    output      logic [krtc_pkg::GRADE_W-1:0]     o_out_grade_a,
    output      logic [krtc_pkg::GRADE_W-1:0]     o_out_grade_b,
    output      logic [krtc_pkg::GRADE_W-1:0]     o_out_grade_c,
    output      logic [krtc_pkg::GRADE_W-1:0]     o_out_grade_d,
    output      logic [krtc_pkg::SUM_W-1:0]       o_grade_sum,
    output      logic                             o_passed,
    output      logic [krtc_pkg::COUNT_W-1:0]     o_entry_count
);
    import krtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RCAP,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [SUM_W-1:0]    r_thresh;
    logic [CNT_W-1:0]    r_fill;
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [CNT_W-1:0]    r_idx;
    logic                r_cmp_v;
    logic [CNT_W-1:0]    r_cmp_idx;
    logic                r_sh_v;
    logic [ADDR_W-1:0]   r_sh_wa;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_pos;
    logic [KEY_W-1:0]    r_rec_key;
    logic [GRD_W-1:0]    r_rec_grd;

    logic                accept;
    logic                add_ok;
    logic                read_ok;
    logic                out_free;
    logic                load_out;
    logic                sh_issue;
    logic [GRD_W-1:0]    in_grades;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [REC_W-1:0]    ram_wdata;
    logic [REC_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]    unit_key_a;
    t_unit_res           unit_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign add_ok      = (r_fill < CNT_W'(CAPACITY));
    assign read_ok     = (32'(i_slot_position) < 32'(r_fill));
    assign out_free    = !o_valid || !i_stall;
    assign load_out    = (r_state == S_DONE) && out_free;
    assign sh_issue    = (r_idx < r_fill);

    assign in_grades = {sat_grade(i_grade_d), sat_grade(i_grade_c),
                        sat_grade(i_grade_b), sat_grade(i_grade_a)};

    // Write port: append on add, otherwise the pending shift move.
    always_comb begin
        if (r_state == S_IDLE) begin
            ram_we    = accept && (i_op == OP_ADD) && add_ok;
            ram_waddr = r_fill[ADDR_W-1:0];
            ram_wdata = {in_grades, i_key_code};
        end else begin
            ram_we    = (r_state == S_SHIFT) && r_sh_v;
            ram_waddr = r_sh_wa;
            ram_wdata = ram_rdata;
        end
    end

    krtc_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign unit_key_a = ram_rdata[KEY_W-1:0];

    krtc_unit u_unit (
        .i_key_a     (unit_key_a),
        .i_key_b     (r_key),
        .i_grades    (r_rec_grd),
        .i_threshold (r_thresh),
        .o_res       (unit_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_ADD:  n_state = S_DONE;
                        OP_READ: n_state = read_ok ? S_READ : S_DONE;
                        default: n_state = (r_fill == '0) ? S_DONE : S_SEARCH;
                    endcase
                end
            end
            S_READ:   n_state = S_RCAP;
            S_RCAP:   n_state = S_DONE;
            S_SEARCH: begin
                if (r_cmp_v) begin
                    if (unit_res.match) begin
                        n_state = (r_op == OP_DEL) ? S_SHIFT : S_DONE;
                    end else if (r_cmp_idx == r_fill - CNT_W'(1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (!sh_issue && !r_sh_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thresh <= THRESH_RESET;
            r_fill   <= '0;
            r_cmp_v  <= 1'b0;
            r_sh_v   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end

            // Load a finished result, or drop the one just taken.
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_op;
                        r_key   <= i_key_code;
                        r_cmp_v <= 1'b0;
                        r_sh_v  <= 1'b0;
                        case (i_op)
                            OP_ADD: begin
                                if (add_ok) begin
                                    r_status  <= ST_OK;
                                    r_pos     <= r_fill;
                                    r_rec_key <= i_key_code;
                                    r_rec_grd <= in_grades;
                                    r_fill    <= r_fill + CNT_W'(1);
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_READ: begin
                                r_status <= read_ok ? ST_OK : ST_RANGE;
                                r_idx    <= CNT_W'(i_slot_position);
                                r_pos    <= CNT_W'(i_slot_position);
                            end
                            default: begin
                                r_status <= ST_NOTFOUND;
                                r_idx    <= '0;
                            end
                        endcase
                    end
                end
                S_RCAP: begin
                    r_rec_key <= ram_rdata[KEY_W-1:0];
                    r_rec_grd <= ram_rdata[REC_W-1:KEY_W];
                end
                S_SEARCH: begin
                    // Read one entry ahead; compare the one that just arrived.
                    r_cmp_idx <= r_idx;
                    if (r_cmp_v && unit_res.match) begin
                        r_status  <= ST_OK;
                        r_pos     <= r_cmp_idx;
                        r_rec_key <= ram_rdata[KEY_W-1:0];
                        r_rec_grd <= ram_rdata[REC_W-1:KEY_W];
                        r_idx     <= r_cmp_idx + CNT_W'(1);
                        r_cmp_v   <= 1'b0;
                    end else begin
                        r_idx     <= r_idx + CNT_W'(1);
                        r_cmp_v   <= 1'b1;
                    end
                end
                S_SHIFT: begin
                    // Move entry idx down to idx-1, one per cycle.
                    if (sh_issue) begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_sh_wa <= ADDR_W'(r_idx - CNT_W'(1));
                        r_sh_v  <= 1'b1;
                    end else begin
                        r_sh_v <= 1'b0;
                        if (!r_sh_v) begin
                            r_fill <= r_fill - CNT_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_status      <= r_status;
                        o_entry_count <= COUNT_W'(r_fill);
                        if (r_status == ST_OK) begin
                            o_hit_position <= POS_W'(r_pos);
                            o_found_code   <= r_rec_key;
                            o_out_grade_a  <= r_rec_grd[GRADE_W-1:0];
                            o_out_grade_b  <= r_rec_grd[2*GRADE_W-1:GRADE_W];
                            o_out_grade_c  <= r_rec_grd[3*GRADE_W-1:2*GRADE_W];
                            o_out_grade_d  <= r_rec_grd[4*GRADE_W-1:3*GRADE_W];
                            o_grade_sum    <= unit_res.sum;
                            o_passed       <= unit_res.passed;
                        end else begin
                            o_hit_position <= '0;
                            o_found_code   <= '0;
                            o_out_grade_a  <= '0;
                            o_out_grade_b  <= '0;
                            o_out_grade_c  <= '0;
                            o_out_grade_d  <= '0;
                            o_grade_sum    <= '0;
                            o_passed       <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `KRTC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(CAPACITY))
    `KRTC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `KRTC_ASSERT_IMP(a_shift_in_fill, i_clk, i_rst_n, (r_state == S_SHIFT) && r_sh_v, CNT_W'(r_sh_wa) < r_fill)
    `KRTC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_grade_sum == '0) && (o_found_code == '0) && !o_passed)

endmodule

`default_nettype wire
